// ===== src/wmm_pkg.sv =====
`default_nettype none

package wmm_pkg;

    localparam int SAMPLE_W          = 24;
    localparam int MIN_W             = 18;
    localparam int COUNT_W           = 7;
    localparam int WINDOW_DEPTH_DEF  = 64;

    // 999 ms in units of 1/256 ms
    localparam logic [MIN_W-1:0] MIN_CEILING = MIN_W'(999 * 256);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIVGO,
        ST_DIVWAIT,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== src/wmm_ram.sv =====
`default_nettype none

module wmm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/wmm_divider.sv =====
`default_nettype none

module wmm_divider #(
    parameter int DIVIDEND_W = 31,
    parameter int DIVISOR_W  = 7
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic      [DIVIDEND_W-1:0] quotient,
    output logic                       done
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVIDEND_W-1:0] quo_next;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIVISOR_W-1:0]  div_reg;
    logic [DIVISOR_W-1:0]  div_next;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    // one quotient bit per cycle, restoring
    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits  = (trial >= {1'b0, div_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            rem_next = fits ? DIVISOR_W'(trial - {1'b0, div_reg}) : trial[DIVISOR_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

// ===== src/window_min_max_mean.sv =====
//  channel   signals                                    direction
//  sample    sample_valid, sample_stall, sample_time    in (stall out)
//  result    result_valid, result_stall, min_time,      out (stall in)
//            max_time, mean_time, valid_count
//
//  each item is processed in turn:
//  one window entry a cycle through the memory read port, then one mean bit a cycle
//  from the serial divider. sample_stall is high from acceptance until the result is
//  loaded into the output register; a waiting result does not block the next item.
//  reset clears a fill count, entries beyond it read as empty, so no clearing pass.

`default_nettype none

module window_min_max_mean #(
    parameter int WINDOW_DEPTH = wmm_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          sample_valid,
    output logic                               sample_stall,
    input  wire logic [wmm_pkg::SAMPLE_W-1:0]  sample_time,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic      [wmm_pkg::MIN_W-1:0]     min_time,
    output logic      [wmm_pkg::SAMPLE_W-1:0]  max_time,
    output logic      [wmm_pkg::SAMPLE_W-1:0]  mean_time,
    output logic      [wmm_pkg::COUNT_W-1:0]   valid_count
);

    localparam int AW    = $clog2(WINDOW_DEPTH);
    localparam int CW    = $clog2(WINDOW_DEPTH + 1);
    localparam int SW    = wmm_pkg::SAMPLE_W;
    localparam int MW    = wmm_pkg::MIN_W;
    localparam int SUM_W = SW + CW;

    wmm_pkg::state_t state_reg;
    wmm_pkg::state_t state_next;

    logic [AW-1:0]    wptr_reg;
    logic [AW-1:0]    wptr_next;
    logic [CW-1:0]    fill_reg;
    logic [CW-1:0]    fill_next;
    logic [CW-1:0]    scan_reg;
    logic [CW-1:0]    scan_next;
    logic             pend_reg;
    logic             pend_next;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [MW-1:0]    lo_reg;
    logic [MW-1:0]    lo_next;
    logic [SW-1:0]    hi_reg;
    logic [SW-1:0]    hi_next;
    logic             rvalid_reg;
    logic             rvalid_next;
    logic [MW-1:0]    min_reg;
    logic [SW-1:0]    max_reg;
    logic [SW-1:0]    mean_reg;
    logic [wmm_pkg::COUNT_W-1:0] vcount_reg;

    logic             accept;
    logic             ram_we;
    logic             scan_run;
    logic             scan_end;
    logic             div_start;
    logic             div_done;
    logic             load_result;
    logic [SW-1:0]    rd_data;
    logic [SUM_W-1:0] quotient;

    assign accept   = sample_valid && !sample_stall;
    assign scan_end = (scan_reg == CW'(WINDOW_DEPTH));

    wmm_ram #(
        .WIDTH (SW),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wptr_reg),
        .wdata (sample_time),
        .raddr (scan_reg[AW-1:0]),
        .rdata (rd_data)
    );

    wmm_divider #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wmm_pkg::ST_IDLE:
            begin
                if (sample_valid)
                begin
                    state_next = wmm_pkg::ST_SCAN;
                end
            end
            wmm_pkg::ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = wmm_pkg::ST_DIVGO;
                end
            end
            wmm_pkg::ST_DIVGO:
            begin
                state_next = wmm_pkg::ST_DIVWAIT;
            end
            wmm_pkg::ST_DIVWAIT:
            begin
                if (div_done)
                begin
                    state_next = wmm_pkg::ST_DONE;
                end
            end
            wmm_pkg::ST_DONE:
            begin
                if (!rvalid_reg || !result_stall)
                begin
                    state_next = wmm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wmm_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        sample_stall = 1'b1;
        ram_we       = 1'b0;
        scan_run     = 1'b0;
        div_start    = 1'b0;
        load_result  = 1'b0;
        unique case (state_reg)
            wmm_pkg::ST_IDLE:
            begin
                sample_stall = 1'b0;
                ram_we       = sample_valid;
            end
            wmm_pkg::ST_SCAN:
            begin
                scan_run = 1'b1;
            end
            wmm_pkg::ST_DIVGO:
            begin
                div_start = 1'b1;
            end
            wmm_pkg::ST_DIVWAIT:
            begin
                sample_stall = 1'b1;
            end
            wmm_pkg::ST_DONE:
            begin
                load_result = !rvalid_reg || !result_stall;
            end
            default:
            begin
                sample_stall = 1'b1;
            end
        endcase
    end

    // window bookkeeping and scan accumulation
    always_comb
    begin
        wptr_next  = wptr_reg;
        fill_next  = fill_reg;
        scan_next  = scan_reg;
        pend_next  = 1'b0;
        sum_next   = sum_reg;
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        if (accept)
        begin
            wptr_next  = (wptr_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : wptr_reg + AW'(1);
            if (fill_reg != CW'(WINDOW_DEPTH))
            begin
                fill_next = fill_reg + CW'(1);
            end
            scan_next  = '0;
            sum_next   = '0;
            count_next = '0;
            lo_next    = wmm_pkg::MIN_CEILING;
            hi_next    = '0;
        end
        if (scan_run)
        begin
            // entries at or past the fill count were never written and read as empty
            pend_next = (scan_reg < fill_reg);
            if (!scan_end)
            begin
                scan_next = scan_reg + CW'(1);
            end
            if (pend_reg && (rd_data != '0))
            begin
                sum_next   = sum_reg + SUM_W'(rd_data);
                count_next = count_reg + CW'(1);
                if (rd_data < {{(SW - MW){1'b0}}, lo_reg})
                begin
                    lo_next = rd_data[MW-1:0];
                end
                if (rd_data > hi_reg)
                begin
                    hi_next = rd_data;
                end
            end
        end
    end

    always_comb
    begin
        rvalid_next = rvalid_reg;
        if (result_valid && !result_stall)
        begin
            rvalid_next = 1'b0;
        end
        if (load_result)
        begin
            rvalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= wmm_pkg::ST_IDLE;
            wptr_reg   <= '0;
            fill_reg   <= '0;
            scan_reg   <= '0;
            pend_reg   <= 1'b0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wptr_reg   <= wptr_next;
            fill_reg   <= fill_next;
            scan_reg   <= scan_next;
            pend_reg   <= pend_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg   <= sum_next;
        count_reg <= count_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        if (load_result)
        begin
            min_reg    <= lo_reg;
            max_reg    <= hi_reg;
            mean_reg   <= (count_reg == '0) ? '0 : quotient[SW-1:0];
            vcount_reg <= wmm_pkg::COUNT_W'(count_reg);
        end
    end

    assign result_valid = rvalid_reg;
    assign min_time     = min_reg;
    assign max_time     = max_reg;
    assign mean_time    = mean_reg;
    assign valid_count  = vcount_reg;

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == wmm_pkg::ST_SCAN) && (scan_reg == '0))
        else $error("accepted item did not start a scan from entry zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(WINDOW_DEPTH))
        else $error("fill count beyond window depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wmm_pkg::ST_DIVWAIT || state_reg == wmm_pkg::ST_DONE)
            |-> (count_reg <= fill_reg) && (lo_reg <= wmm_pkg::MIN_CEILING))
        else $error("scan totals out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == wmm_pkg::ST_DIVWAIT))
        else $error("divider finished outside its wait state");
`endif

endmodule

`default_nettype wire
